>>> rtl/core/ripqt_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Range-increment point-query tree: shared types and constants
// Field widths, operation and status codes, saturating counter arithmetic.
// -----------------------------------------------------------------------------
package ripqt_pkg;

   localparam int CountWidth = 32;
   localparam int FirstWidth = 10;
   localparam int EndWidth   = 11;
   localparam int SizeWidth  = 11;

   localparam logic [SizeWidth-1:0]  SIZE_RESET = 11'd1024;
   localparam logic [CountWidth-1:0] COUNT_SAT  = '1;

   typedef enum logic {
      OP_INCREMENT = 1'b0,
      OP_QUERY     = 1'b1
   } op_type;

   typedef enum logic {
      ST_DONE  = 1'b0,
      ST_RANGE = 1'b1
   } status_type;

   // bump a node counter, holding at full scale
   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == COUNT_SAT) ? v : v + 1'b1;
   endfunction

   // add two counts, holding at full scale
   function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] a,
                                                      input logic [CountWidth-1:0] b);
      logic [CountWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[CountWidth] ? COUNT_SAT : s[CountWidth-1:0];
   endfunction

endpackage

>>> rtl/core/ripqt_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module ripqt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/range_increment_point_query_tree.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Range-increment point-query counter tree
// Bottom-up segment tree of saturating 32-bit counters held in one RAM.
// -----------------------------------------------------------------------------
// Usage:
//   req channel: one request per handshake. tuser is the operation
//   (increment a range or query a position), tdata carries first_index and
//   range_end. rsp channel: exactly one response per request, count in tdata,
//   status in tuser (set when a request is rejected).
//   csr_wr_en/csr_wr_data write size_in_use; write it only while idle.
//   Requests are worked one at a time. A query reads one tree level per
//   cycle (pipelined reads of the node RAM). An increment checks each level
//   in S_UCHK and writes each covering node back in S_ULO or S_UHI through
//   the single RAM port pair. Rejected requests (indices beyond the size in
//   use, or an increment with first_index above range_end) go straight to
//   S_DONE without touching the node RAM. After reset the node RAM is
//   cleared one entry a cycle, all 2*LEAVES entries, with req_tready low.
//   A stalled response sits in the output register; the next request is
//   taken meanwhile and its result holds until the slot frees.
// -----------------------------------------------------------------------------
module range_increment_point_query_tree
   import ripqt_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [9:0] first_index, [20:10] range_end, zero pad
   input  logic                  req_tuser,   // [0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CountWidth-1:0] rsp_tdata,   // [31:0] count
   output logic                  rsp_tuser,   // [0] status
   input  logic                  csr_wr_en,
   input  logic [SizeWidth-1:0]  csr_wr_data
);

   localparam int Depth = 2 * LEAVES;
   localparam int NW    = $clog2(Depth);
   localparam int WW    = ((NW > SizeWidth) ? NW : SizeWidth) + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_UCHK,
      S_ULO,
      S_UHI,
      S_QRY,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [SizeWidth-1:0]  size_ff;
   logic [WW-1:0]         lo_ff, lo_in;
   logic [WW-1:0]         hi_ff, hi_in;
   logic [CountWidth-1:0] sum_ff, sum_in;
   logic                  pend_ff, pend_in;
   logic [NW-1:0]         clr_ff, clr_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  mem_we;
   logic [NW-1:0]         mem_wa;
   logic [CountWidth-1:0] mem_wd;
   logic [NW-1:0]         mem_ra;
   logic [CountWidth-1:0] mem_rd;

   logic [WW-1:0]         size_w, n_w, first_w, end_w, hi_dec;
   logic                  req_fire;
   op_type                req_op;

   ripqt_ram #(
      .WIDTH (CountWidth),
      .DEPTH (Depth)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);

   // clamp the configured size into 1..LEAVES
   assign size_w  = WW'(size_ff);
   assign n_w     = (size_ff == '0) ? WW'(1) :
                    ((size_w > WW'(LEAVES)) ? WW'(LEAVES) : size_w);
   assign first_w = WW'(req_tdata[FirstWidth-1:0]);
   assign end_w   = WW'(req_tdata[FirstWidth +: EndWidth]);
   assign hi_dec  = hi_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sum_in        = sum_ff;
      pend_in       = pend_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_wa        = lo_ff[NW-1:0];
      mem_wd        = sat_inc(mem_rd);
      mem_ra        = lo_ff[NW-1:0];

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == NW'(Depth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               sum_in    = '0;
               pend_in   = 1'b0;
               status_in = ST_DONE;
               lo_in     = first_w + n_w;
               hi_in     = end_w + n_w;
               if (req_op == OP_QUERY) begin
                  if (first_w >= n_w) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_QRY;
                  end
               end else begin
                  if (end_w > n_w || first_w > end_w) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_UCHK;
                  end
               end
            end
         end
         S_QRY: begin
            // read one level a cycle, add each level's data the cycle after its read
            pend_in = 1'b0;
            if (pend_ff) begin
               sum_in = sat_add(sum_ff, mem_rd);
            end
            if (lo_ff != '0) begin
               mem_ra  = lo_ff[NW-1:0];
               pend_in = 1'b1;
               lo_in   = lo_ff >> 1;
            end else if (!pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_UCHK: begin
            if (lo_ff >= hi_ff) begin
               state_in = S_DONE;
            end else if (lo_ff[0]) begin
               mem_ra   = lo_ff[NW-1:0];
               state_in = S_ULO;
            end else if (hi_ff[0]) begin
               mem_ra   = hi_dec[NW-1:0];
               state_in = S_UHI;
            end else begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
            end
         end
         S_ULO: begin
            // write back the left node; the right read goes to another entry
            mem_we = 1'b1;
            mem_wa = lo_ff[NW-1:0];
            if (hi_ff[0]) begin
               mem_ra   = hi_dec[NW-1:0];
               lo_in    = lo_ff + 1'b1;
               state_in = S_UHI;
            end else begin
               lo_in    = (lo_ff + 1'b1) >> 1;
               hi_in    = hi_ff >> 1;
               state_in = S_UCHK;
            end
         end
         S_UHI: begin
            mem_we   = 1'b1;
            mem_wa   = hi_dec[NW-1:0];
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            state_in = S_UCHK;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = sum_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         size_ff       <= SIZE_RESET;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= ST_DONE;
         rsp_status_ff <= ST_DONE;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         status_ff     <= status_in;
         rsp_status_ff <= rsp_status_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      sum_ff       <= sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected request carries a nonzero count");

   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff != S_CLEAR |-> mem_wa != '0)
      else $error("node write to unused entry zero");

   a_lo_le_hi: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UCHK |-> lo_ff <= hi_ff)
      else $error("range walk crossed its bounds");

   a_clear_first: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request taken before node clearing");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ULO || state_ff == S_UHI |-> hi_ff <= WW'(Depth))
      else $error("range walk beyond node store");
`endif

endmodule
